// ===== sv/sap_pkg.sv =====
// Shared types and constants of the shadow atlas slot allocator.
package sap_pkg;

	localparam logic [14:0] RESET_ATLAS_SIZE = 15'd4096;
	localparam logic [14:0] MAX_ATLAS_SIZE   = 15'd16384;
	localparam logic [2:0]  EIGHTH_FIRST_ROW = 3'd6;

	localparam logic [1:0] SIZE_HALF    = 2'd0;
	localparam logic [1:0] SIZE_QUARTER = 2'd1;
	localparam logic [1:0] SIZE_EIGHTH  = 2'd2;

	typedef enum logic [1:0] {
		ST_GRANT  = 2'd0,
		ST_DONE   = 2'd1,
		ST_NOROOM = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_DONE    = 2'd1,
		CMD_BADSIZE = 2'd2,
		CMD_ALLOC   = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [1:0]  slot_size;
		logic [4:0]  count;
	} cmd_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_SCAN = 1'b1
	} back_state_t;

endpackage

// ===== sv/sap_front.sv =====
// Front end: accepts request items and classifies them into queued commands.
module sap_front import sap_pkg::*; (
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // slot_size[1:0], count[6:2], zero[7]
	input  logic       s_tuser,   // mode
	input  logic       queue_full,
	output logic       push,
	output cmd_t       cmd
);

	logic [1:0] slot_size;
	logic [4:0] count;

	assign slot_size = s_tdata[1:0];
	assign count     = s_tdata[6:2];
	assign s_tready  = !queue_full;
	assign push      = s_tvalid && !queue_full;

	always_comb begin
		cmd.slot_size = slot_size;
		cmd.count     = count;
		priority if (!s_tuser) begin
			cmd.kind = CMD_CLEAR;
		end else if (count == 5'd0) begin
			cmd.kind = CMD_DONE;
		end else if (slot_size != SIZE_HALF && slot_size != SIZE_QUARTER
				&& slot_size != SIZE_EIGHTH) begin
			cmd.kind = CMD_BADSIZE;
		end else begin
			cmd.kind = CMD_ALLOC;
		end
	end

endmodule

// ===== sv/sap_fifo.sv =====
// Small register queue between the front end and the allocation engine.
module sap_fifo #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/sap_back.sv =====
// Allocation engine: holds the slot maps, scans for free slots and emits results.
module sap_back import sap_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [14:0] cfg_wdata,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	back_state_t state_q;
	back_state_t state_d;

	logic [14:0] atlas_size_q;
	logic [3:0]  half_used_q;
	logic [11:0] quarter_used_q;
	logic [15:0] eighth_used_q;

	logic [3:0]  idx_q;
	logic [4:0]  k_q;
	logic [4:0]  count_q;
	logic [1:0]  size_q;
	logic [13:0] res_q;

	logic        out_valid_q;
	logic [47:0] out_data_q;
	status_t     out_status_q;
	logic        out_last_q;

	logic        out_free;
	logic [4:0]  free_cnt;
	logic [14:0] edge_len;
	logic [13:0] res_d;
	logic [15:0] cur_map;
	logic        cur_free;
	logic        is_last;
	logic [2:0]  col;
	logic [2:0]  row;
	logic [16:0] x_full;
	logic [16:0] y_full;

	logic        load_out;
	logic [47:0] out_word;
	status_t     out_status;
	logic        out_last;
	logic        clear_maps;
	logic        start_scan;
	logic        advance;
	logic        set_bit;

	assign out_free = !out_valid_q || m_tready;
	assign edge_len = (atlas_size_q > MAX_ATLAS_SIZE) ? MAX_ATLAS_SIZE : atlas_size_q;

	always_comb begin
		unique case (cmd.slot_size)
			SIZE_HALF: begin
				free_cnt = 5'($countones(~half_used_q));
				res_d    = 14'(edge_len >> 1);
			end
			SIZE_QUARTER: begin
				free_cnt = 5'($countones(~quarter_used_q));
				res_d    = 14'(edge_len >> 2);
			end
			default: begin
				free_cnt = 5'($countones(~eighth_used_q));
				res_d    = 14'(edge_len >> 3);
			end
		endcase
	end

	always_comb begin
		unique case (size_q)
			SIZE_HALF: begin
				cur_map = {12'd0, half_used_q};
				col     = {2'd0, idx_q[0]};
				row     = {2'd0, idx_q[1]};
			end
			SIZE_QUARTER: begin
				cur_map = {4'd0, quarter_used_q};
				col     = {1'b0, idx_q[1:0]};
				row     = {1'b0, idx_q[3:2]};
			end
			default: begin
				cur_map = eighth_used_q;
				col     = idx_q[2:0];
				row     = EIGHTH_FIRST_ROW + {2'd0, idx_q[3]};
			end
		endcase
	end

	assign cur_free = !cur_map[idx_q];
	assign is_last  = (k_q + 5'd1 == count_q);
	assign x_full   = {14'd0, col} * {3'd0, res_q};
	assign y_full   = {14'd0, row} * {3'd0, res_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid && out_free && cmd.kind == CMD_ALLOC && free_cnt >= cmd.count) begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (out_free && cur_free && is_last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop    = 1'b0;
		load_out   = 1'b0;
		out_word   = '0;
		out_status = ST_GRANT;
		out_last   = 1'b0;
		clear_maps = 1'b0;
		start_scan = 1'b0;
		advance    = 1'b0;
		set_bit    = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						CMD_CLEAR: begin
							cmd_pop    = 1'b1;
							clear_maps = 1'b1;
						end
						CMD_DONE: begin
							cmd_pop    = out_free;
							load_out   = out_free;
							out_status = ST_DONE;
							out_last   = 1'b1;
						end
						CMD_BADSIZE: begin
							cmd_pop    = out_free;
							load_out   = out_free;
							out_status = ST_NOROOM;
							out_last   = 1'b1;
						end
						default: begin
							cmd_pop = out_free;
							if (free_cnt < cmd.count) begin
								load_out   = out_free;
								out_status = ST_NOROOM;
								out_last   = 1'b1;
							end else begin
								start_scan = out_free;
							end
						end
					endcase
				end
			end
			default: begin
				if (out_free) begin
					advance = 1'b1;
					if (cur_free) begin
						set_bit          = 1'b1;
						load_out         = 1'b1;
						out_status       = ST_GRANT;
						out_word[13:0]   = x_full[13:0];
						out_word[27:14]  = y_full[13:0];
						out_word[28]     = (size_q != SIZE_HALF);
						out_word[42:29]  = res_q;
						out_last         = is_last;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= BK_IDLE;
			atlas_size_q   <= RESET_ATLAS_SIZE;
			half_used_q    <= '0;
			quarter_used_q <= '0;
			eighth_used_q  <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				atlas_size_q <= cfg_wdata;
			end
			if (clear_maps) begin
				half_used_q    <= '0;
				quarter_used_q <= '0;
				eighth_used_q  <= '0;
			end else if (set_bit) begin
				unique case (size_q)
					SIZE_HALF:    half_used_q[idx_q[1:0]] <= 1'b1;
					SIZE_QUARTER: quarter_used_q[idx_q]   <= 1'b1;
					default:      eighth_used_q[idx_q]    <= 1'b1;
				endcase
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q   <= out_word;
			out_status_q <= out_status;
			out_last_q   <= out_last;
		end
		if (start_scan) begin
			idx_q   <= '0;
			k_q     <= '0;
			count_q <= cmd.count;
			size_q  <= cmd.slot_size;
			res_q   <= res_d;
		end else if (advance) begin
			idx_q <= idx_q + 4'd1;
			if (set_bit) begin
				k_q <= k_q + 5'd1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	a_scan_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_SCAN |-> k_q < count_q)
		else $error("Scan continued past the requested count.");

	a_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCAN && advance && idx_q == 4'hF) |-> (set_bit && is_last))
		else $error("Scan ran off the end of the slot map.");

	a_grant_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && out_status == ST_GRANT) |-> state_q == BK_SCAN)
		else $error("Grant produced outside of a scan.");

	a_scan_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCAN && state_d == BK_IDLE) |-> (load_out && out_last))
		else $error("Scan ended without a final result.");
`endif

endmodule

// ===== sv/shadow_atlas_slot_allocator_core.sv =====
// Top level of the shadow atlas slot allocator.
// Requests arrive on the s_t* channel: s_tuser is the mode (0 clear, 1 allocate),
// s_tdata carries the slot size and the count. Results leave on the m_t* channel,
// one item per granted slot, or a single done or no-room item, with the status on
// m_tuser and m_tlast on the final item of each request. A clear request produces
// no result item.
// The atlas edge length is written through cfg_wen and cfg_wdata; the user must
// write it only while idle, which the block does not enforce. A request passes
// a short command queue. With the engine idle, a done or no-room item passes the
// queue and the output register; the first grant of an allocation passes the
// queue, the scan state and the output register, after any taken slots scanned
// first. An allocation scans its map (up to 16 slots) one index per cycle while
// the output is free, emitting at most one result per cycle; done, no-room and
// clear commands need no scan. The queue takes requests while the engine is busy.
// When the receiver holds m_tready low the output register holds its item and
// the scan stops; the queue then fills and s_tready falls.
// Reset empties all slot maps, clears the queue and sets the atlas size to 4096.
module shadow_atlas_slot_allocator_core import sap_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [14:0] cfg_wdata,   // atlas_size
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // slot_size[1:0], count[6:2], zero[7]
	input  logic        s_tuser,     // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,     // slot_x[13:0], slot_y[27:14], layer[28],
	                                 // resolution[42:29], zero[47:43]
	output logic [1:0]  m_tuser,     // status[1:0]
	output logic        m_tlast
);

	localparam int CMD_W = $bits(cmd_t);

	cmd_t             front_cmd;
	logic             push;
	logic             queue_full;
	logic [CMD_W-1:0] queue_rd;
	logic             queue_not_empty;
	logic             cmd_pop;

	sap_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.queue_full (queue_full),
		.push       (push),
		.cmd        (front_cmd)
	);

	sap_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   (front_cmd),
		.pop       (cmd_pop),
		.rd_data   (queue_rd),
		.full      (queue_full),
		.not_empty (queue_not_empty)
	);

	sap_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (queue_not_empty),
		.cmd       (cmd_t'(queue_rd)),
		.cmd_pop   (cmd_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
